FILE: hdl/rgrs_pkg.sv
// rgrs_pkg: shared types, codes, gain table and helpers of the receive gain search
// used by every module of rx_gain_row_search and by the channel interfaces
`default_nettype none

package rgrs_pkg;

  // default sizing
  localparam int unsigned GAIN_ROWS_DEF         = 6;
  localparam int unsigned SAMPLE_COUNT_LOG2_DEF = 10;

  localparam int unsigned SUM_W   = 32;
  localparam int unsigned PWR_W   = 24;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // status codes
  localparam logic [1:0] ST_MEASURE = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POWER_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESIRED_LOG2_POWER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VGA_GAIN_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIXER_TIA_GAIN     = 3'd4;

  typedef struct packed {
    logic [PWR_W-1:0] power_threshold;
    logic [4:0]       desired_log2_power;
    logic [ROW_W-1:0] start_row;
    logic [3:0]       vga_gain_limit;
    logic [3:0]       mixer_tia_gain;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic             rx_core;
    logic [SUM_W-1:0] core0_i_power_sum;
    logic [SUM_W-1:0] core0_q_power_sum;
    logic [SUM_W-1:0] core1_i_power_sum;
    logic [SUM_W-1:0] core1_q_power_sum;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       gain_word;
    logic signed [7:0] tx_power_index;
    logic              tx_core;
    logic [ROW_W-1:0]  best_row;
    logic [PWR_W-1:0]  best_power;
  } rsp_t;

  typedef struct packed {
    logic [3:0]        hpvga;
    logic [1:0]        biq1;
    logic [1:0]        biq0;
    logic [1:0]        lna2;
    logic [1:0]        lna1;
    logic signed [7:0] txidx;
  } gain_row_t;

  // fixed gain table, rows from six upward repeat the last row
  function automatic gain_row_t gain_row(input logic [ROW_W-1:0] row);
    gain_row_t r;
    r = '0;
    case (row)
      3'd0: r.txidx = -8'sd128;
      3'd1: r.txidx = 8'sd70;
      3'd2: r.txidx = 8'sd20;
      3'd3: begin
        r.lna2  = 2'd3;
        r.txidx = 8'sd20;
      end
      3'd4: begin
        r.biq0  = 2'd3;
        r.lna2  = 2'd3;
        r.txidx = 8'sd20;
      end
      default: begin
        r.biq1  = 2'd2;
        r.biq0  = 2'd3;
        r.lna2  = 2'd3;
        r.txidx = 8'sd20;
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pack_gain(input logic [3:0] hp, input gain_row_t r,
                                            input logic [3:0] mixer);
    return {hp, r.biq1, r.biq0, mixer, r.lna2, r.lna1};
  endfunction

  // position of the highest set bit plus one, zero for zero
  function automatic logic [4:0] bit_length(input logic [PWR_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int unsigned i = 0; i < PWR_W; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgrs_if.sv
// rgrs_req_if / rgrs_rsp_if: valid/ready channels of the receive gain search
// depend on rgrs_pkg for field widths
`default_nettype none

interface rgrs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic                      rx_core;
  logic [rgrs_pkg::SUM_W-1:0] core0_i_power_sum;
  logic [rgrs_pkg::SUM_W-1:0] core0_q_power_sum;
  logic [rgrs_pkg::SUM_W-1:0] core1_i_power_sum;
  logic [rgrs_pkg::SUM_W-1:0] core1_q_power_sum;

  modport source (
    output valid, operation, rx_core, core0_i_power_sum, core0_q_power_sum,
           core1_i_power_sum, core1_q_power_sum,
    input  ready
  );
  modport sink (
    input  valid, operation, rx_core, core0_i_power_sum, core0_q_power_sum,
           core1_i_power_sum, core1_q_power_sum,
    output ready
  );
endinterface

interface rgrs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [15:0]               gain_word;
  logic signed [7:0]         tx_power_index;
  logic                      tx_core;
  logic [rgrs_pkg::ROW_W-1:0] best_row;
  logic [rgrs_pkg::PWR_W-1:0] best_power;

  modport source (
    output valid, status, gain_word, tx_power_index, tx_core, best_row, best_power,
    input  ready
  );
  modport sink (
    input  valid, status, gain_word, tx_power_index, tx_core, best_row, best_power,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/rgrs_cfg_regs.sv
// rgrs_cfg_regs: configuration registers of the receive gain search
// depends on rgrs_pkg
`default_nettype none

module rgrs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rgrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rgrs_pkg::CFG_W-1:0]     cfg_data_i,
  output rgrs_pkg::cfg_t                      cfg_o
);
  import rgrs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_threshold    <= 24'd10000;
      cfg_q.desired_log2_power <= 5'd13;
      cfg_q.start_row          <= 3'd3;
      cfg_q.vga_gain_limit     <= 4'd10;
      cfg_q.mixer_tia_gain     <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POWER_THRESHOLD:    cfg_q.power_threshold    <= cfg_data_i;
        REG_DESIRED_LOG2_POWER: cfg_q.desired_log2_power <= cfg_data_i[4:0];
        REG_START_ROW:          cfg_q.start_row          <= cfg_data_i[ROW_W-1:0];
        REG_VGA_GAIN_LIMIT:     cfg_q.vga_gain_limit     <= cfg_data_i[3:0];
        REG_MIXER_TIA_GAIN:     cfg_q.mixer_tia_gain     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/rgrs_power.sv
// rgrs_power: picks the sums of the selected core, rounds each and adds them
// depends on rgrs_pkg
`default_nettype none

module rgrs_power #(
  parameter int unsigned SAMPLE_COUNT_LOG2 = rgrs_pkg::SAMPLE_COUNT_LOG2_DEF
) (
  input  wire rgrs_pkg::req_t             item_i,
  input  wire logic                       core_i,
  output logic [rgrs_pkg::PWR_W-1:0]      power_o
);
  import rgrs_pkg::*;

  localparam logic [SUM_W:0] HALF = (SUM_W+1)'(1) << (SAMPLE_COUNT_LOG2 - 1);

  logic [SUM_W-1:0] sum_i, sum_q;
  logic [SUM_W:0]   rnd_i, rnd_q;

  always_comb begin
    sum_i = core_i ? item_i.core1_i_power_sum : item_i.core0_i_power_sum;
    sum_q = core_i ? item_i.core1_q_power_sum : item_i.core0_q_power_sum;
    // round to nearest, carry kept in the extra bit
    rnd_i = ({1'b0, sum_i} + HALF) >> SAMPLE_COUNT_LOG2;
    rnd_q = ({1'b0, sum_q} + HALF) >> SAMPLE_COUNT_LOG2;
  end

  assign power_o = PWR_W'(rnd_i + rnd_q);

endmodule

`default_nettype wire

FILE: hdl/rgrs_walk.sv
// rgrs_walk: search state and row walk, forms one result per request
// depends on rgrs_pkg
`default_nettype none

module rgrs_walk #(
  parameter int unsigned GAIN_ROWS = rgrs_pkg::GAIN_ROWS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire rgrs_pkg::req_t        item_i,
  input  wire rgrs_pkg::cfg_t        cfg_i,
  input  wire logic [rgrs_pkg::PWR_W-1:0] power_i,
  output logic                       sel_core_o,
  output rgrs_pkg::rsp_t             rsp_o
);
  import rgrs_pkg::*;

  localparam logic [1:0] DIR_INIT = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GAIN_ROWS - 1);
  localparam logic [ROW_W:0]   ROWS     = (ROW_W+1)'(GAIN_ROWS);

  logic             search_q, search_d;
  logic [1:0]       dir_q, dir_d;
  logic [3:0]       cur_q, cur_d;
  logic [ROW_W-1:0] prev_row_q, prev_row_d;
  logic [PWR_W-1:0] prev_pwr_q, prev_pwr_d;
  logic             sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_q   <= 1'b0;
      dir_q      <= DIR_INIT;
      cur_q      <= '0;
      prev_row_q <= '0;
      prev_pwr_q <= '0;
      sel_q      <= 1'b0;
    end else if (step_i) begin
      search_q   <= search_d;
      dir_q      <= dir_d;
      cur_q      <= cur_d;
      prev_row_q <= prev_row_d;
      prev_pwr_q <= prev_pwr_d;
      sel_q      <= sel_d;
    end
  end

  assign sel_core_o = sel_q;

  always_comb begin
    logic [ROW_W-1:0] cur;
    logic             gt;
    logic             done;
    logic             oob;
    logic [ROW_W-1:0] opt_row;
    logic [PWR_W-1:0] opt_pwr;
    logic signed [6:0] hp;
    gain_row_t        row;

    search_d   = search_q;
    dir_d      = dir_q;
    cur_d      = cur_q;
    prev_row_d = prev_row_q;
    prev_pwr_d = prev_pwr_q;
    sel_d      = sel_q;

    cur     = cur_q[ROW_W-1:0];
    gt      = power_i > cfg_i.power_threshold;
    done    = 1'b0;
    oob     = 1'b0;
    opt_row = cur;
    opt_pwr = power_i;
    hp      = '0;
    row     = gain_row(cur);

    rsp_o         = '0;
    rsp_o.tx_core = ~sel_q;

    if (item_i.operation == OP_START) begin
      sel_d         = item_i.rx_core;
      dir_d         = DIR_INIT;
      prev_row_d    = '0;
      prev_pwr_d    = '0;
      rsp_o.tx_core = ~item_i.rx_core;
      if ({1'b0, cfg_i.start_row} >= ROWS) begin
        search_d     = 1'b0;
        cur_d        = '0;
        rsp_o.status = ST_RANGE;
      end else begin
        search_d             = 1'b1;
        cur_d                = {1'b0, cfg_i.start_row};
        row                  = gain_row(cfg_i.start_row);
        rsp_o.status         = ST_MEASURE;
        rsp_o.gain_word      = pack_gain(row.hpvga, row, cfg_i.mixer_tia_gain);
        rsp_o.tx_power_index = row.txidx;
      end
    end else if (!search_q) begin
      rsp_o.status = ST_RANGE;
    end else if (power_i == '0) begin
      search_d     = 1'b0;
      rsp_o.status = ST_ZERO;
    end else begin
      unique case (dir_q)
        DIR_UP: begin
          if (gt) begin
            done    = 1'b1;
            opt_row = prev_row_q;
            opt_pwr = prev_pwr_q;
          end else begin
            prev_row_d = cur;
            cur_d      = cur_q + 4'd1;
            oob        = (cur == LAST_ROW);
          end
        end
        DIR_DOWN: begin
          if (gt) begin
            prev_row_d = cur;
            cur_d      = cur_q - 4'd1;
            oob        = (cur == '0);
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          // first measurement sets the walk direction
          dir_d      = gt ? DIR_DOWN : DIR_UP;
          prev_row_d = cur;
          cur_d      = gt ? (cur_q - 4'd1) : (cur_q + 4'd1);
          oob        = gt ? (cur == '0) : (cur == LAST_ROW);
        end
      endcase

      // stepping off either end ends the walk at the measured row
      if (oob) begin
        done    = 1'b1;
        opt_row = cur;
        opt_pwr = power_i;
      end else begin
        prev_pwr_d = power_i;
      end

      if (!done) begin
        row                  = gain_row(cur_d[ROW_W-1:0]);
        rsp_o.status         = ST_MEASURE;
        rsp_o.gain_word      = pack_gain(row.hpvga, row, cfg_i.mixer_tia_gain);
        rsp_o.tx_power_index = row.txidx;
      end else begin
        search_d = 1'b0;
        if (opt_pwr == '0 || {1'b0, opt_row} >= ROWS) begin
          rsp_o.status = ST_RANGE;
        end else begin
          row = gain_row(opt_row);
          hp  = 7'(signed'({3'b000, row.hpvga})) + 7'(signed'({2'b00, cfg_i.desired_log2_power}))
                - 7'(signed'({2'b00, bit_length(opt_pwr)}));
          if (hp < 7'sd0) hp = 7'sd0;
          if (hp > 7'(signed'({3'b000, cfg_i.vga_gain_limit}))) begin
            hp = 7'(signed'({3'b000, cfg_i.vga_gain_limit}));
          end
          rsp_o.status         = ST_DONE;
          rsp_o.gain_word      = pack_gain(hp[3:0], row, cfg_i.mixer_tia_gain);
          rsp_o.tx_power_index = gain_row(cur).txidx;
          rsp_o.best_row       = opt_row;
          rsp_o.best_power     = opt_pwr;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rx_gain_row_search.sv
// rx_gain_row_search: top level of the receive gain search
// depends on rgrs_pkg, rgrs_if, rgrs_cfg_regs, rgrs_power and rgrs_walk
`default_nettype none

// Takes one request per clock while the result side accepts, and returns one
// result per request, in order. A request is latched in an input register, the
// power rounding and the row walk settle in one combinational stage, and the
// result sits in an output register: one request per cycle sustained, set by the
// single compute stage between the two registers.
// Back pressure on the result side stalls the input register, which still
// frees in the same cycle the result is taken. Configuration writes are
// expected only while no request is in flight.
module rx_gain_row_search #(
  parameter int unsigned GAIN_ROWS         = rgrs_pkg::GAIN_ROWS_DEF,
  parameter int unsigned SAMPLE_COUNT_LOG2 = rgrs_pkg::SAMPLE_COUNT_LOG2_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rgrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rgrs_pkg::CFG_W-1:0]     cfg_data_i,
  rgrs_req_if.sink                            req,
  rgrs_rsp_if.source                          rsp
);
  import rgrs_pkg::*;

  logic             in_vld_q;
  req_t             in_q;
  logic             out_vld_q;
  rsp_t             out_q;
  logic             advance;
  cfg_t             cfg;
  logic             sel_core;
  logic [PWR_W-1:0] power;
  rsp_t             walk_rsp;

  assign advance   = in_vld_q && (!out_vld_q || rsp.ready);
  assign req.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.ready) begin
      in_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_q.operation         <= req.operation;
      in_q.rx_core           <= req.rx_core;
      in_q.core0_i_power_sum <= req.core0_i_power_sum;
      in_q.core0_q_power_sum <= req.core0_q_power_sum;
      in_q.core1_i_power_sum <= req.core1_i_power_sum;
      in_q.core1_q_power_sum <= req.core1_q_power_sum;
    end
  end

  rgrs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rgrs_power #(
    .SAMPLE_COUNT_LOG2 (SAMPLE_COUNT_LOG2)
  ) u_power (
    .item_i  (in_q),
    .core_i  (sel_core),
    .power_o (power)
  );

  rgrs_walk #(
    .GAIN_ROWS (GAIN_ROWS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .cfg_i      (cfg),
    .power_i    (power),
    .sel_core_o (sel_core),
    .rsp_o      (walk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= walk_rsp;
    end
  end

  assign rsp.valid          = out_vld_q;
  assign rsp.status         = out_q.status;
  assign rsp.gain_word      = out_q.gain_word;
  assign rsp.tx_power_index = out_q.tx_power_index;
  assign rsp.tx_core        = out_q.tx_core;
  assign rsp.best_row       = out_q.best_row;
  assign rsp.best_power     = out_q.best_power;

endmodule

`default_nettype wire

FILE: tb/rgrs_search_checker.sv
// rgrs_search_checker: watches the request, result and register ports of rx_gain_row_search,
// predicts every result of the gain row walk and compares it with what the block returns
// depends on rgrs_pkg and the rgrs_req_if / rgrs_rsp_if channels
`default_nettype none

module rgrs_search_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rgrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rgrs_pkg::CFG_W-1:0]     cfg_data_i,
  rgrs_req_if                                 req,
  rgrs_rsp_if                                 rsp,
  output int unsigned                         outstanding_o,
  output int unsigned                         mismatch_cnt_o
);
  import rgrs_pkg::*;

  localparam int ROWS     = GAIN_ROWS_DEF;
  localparam int SHIFT    = SAMPLE_COUNT_LOG2_DEF;

  typedef enum logic [1:0] {WALK_INIT, WALK_UP, WALK_DOWN} walk_e;

  // register shadow
  logic [PWR_W-1:0] thr_q;
  logic [4:0]       log2_q;
  logic [ROW_W-1:0] srow_q;
  logic [3:0]       vlim_q;
  logic [3:0]       mixer_q;

  // walk state
  bit               searching_q;
  walk_e            walk_q;
  int               cur_row_q;
  int               prev_row_q;
  logic [PWR_W-1:0] prev_pwr_q;
  bit               core_q;

  rsp_t             pending_results_q[$];
  int unsigned      fails;

  function automatic logic signed [7:0] tx_index_of(input int row);
    if (row == 0) return -8'sd128;
    if (row == 1) return 8'sd70;
    return 8'sd20;
  endfunction

  // table rows only differ in lna2, biquad0 and biquad1, hpvga and lna1 stay zero
  function automatic logic [15:0] gain_word_of(input int row, input int hp);
    logic [3:0] hp_f;
    logic [1:0] lna2_f, biq0_f, biq1_f;
    hp_f   = 4'(hp);
    lna2_f = (row >= 3) ? 2'd3 : 2'd0;
    biq0_f = (row >= 4) ? 2'd3 : 2'd0;
    biq1_f = (row >= 5) ? 2'd2 : 2'd0;
    return {hp_f, biq1_f, biq0_f, mixer_q, lna2_f, 2'b00};
  endfunction

  function automatic int bit_len(input logic [PWR_W-1:0] v);
    int n;
    n = 0;
    for (int i = 0; i < PWR_W; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic longint unsigned rounded(input logic [SUM_W-1:0] s);
    return (longint'(s) + (longint'(1) << (SHIFT - 1))) >> SHIFT;
  endfunction

  function automatic rsp_t predict_search_result(input req_t r);
    rsp_t             e;
    logic [SUM_W-1:0] si, sq;
    logic [PWR_W-1:0] pwr, opt_pwr;
    int               opt_row, measured, hp;
    bit               done, above;
    e       = '0;
    opt_pwr = '0;
    opt_row = 0;
    done    = 1'b0;
    if (r.operation == OP_START) begin
      core_q     = r.rx_core;
      walk_q     = WALK_INIT;
      prev_row_q = 0;
      prev_pwr_q = '0;
      e.tx_core  = ~core_q;
      if (int'(srow_q) >= ROWS) begin
        searching_q = 1'b0;
        cur_row_q   = 0;
        e.status    = ST_RANGE;
      end else begin
        cur_row_q        = int'(srow_q);
        searching_q      = 1'b1;
        e.status         = ST_MEASURE;
        e.gain_word      = gain_word_of(cur_row_q, 0);
        e.tx_power_index = tx_index_of(cur_row_q);
      end
      return e;
    end
    e.tx_core = ~core_q;
    if (!searching_q) begin
      e.status = ST_RANGE;
      return e;
    end
    si  = core_q ? r.core1_i_power_sum : r.core0_i_power_sum;
    sq  = core_q ? r.core1_q_power_sum : r.core0_q_power_sum;
    pwr = PWR_W'(rounded(si) + rounded(sq));
    if (pwr == '0) begin
      searching_q = 1'b0;
      e.status    = ST_ZERO;
      return e;
    end
    measured = cur_row_q;
    above    = (pwr > thr_q);
    case (walk_q)
      WALK_UP: begin
        if (above) begin
          done    = 1'b1;
          opt_pwr = prev_pwr_q;
          opt_row = prev_row_q;
        end else begin
          prev_row_q = cur_row_q;
          cur_row_q  = cur_row_q + 1;
        end
      end
      WALK_DOWN: begin
        if (above) begin
          prev_row_q = cur_row_q;
          cur_row_q  = cur_row_q - 1;
        end else begin
          done    = 1'b1;
          opt_pwr = pwr;
          opt_row = cur_row_q;
        end
      end
      default: begin
        walk_q     = above ? WALK_DOWN : WALK_UP;
        prev_row_q = cur_row_q;
        cur_row_q  = above ? cur_row_q - 1 : cur_row_q + 1;
      end
    endcase
    // walking off either end of the table ends the search at the last row inside
    if (cur_row_q < 0 || cur_row_q >= ROWS) begin
      done    = 1'b1;
      opt_pwr = pwr;
      opt_row = prev_row_q;
    end else begin
      prev_pwr_q = pwr;
    end
    if (!done) begin
      e.status         = ST_MEASURE;
      e.gain_word      = gain_word_of(cur_row_q, 0);
      e.tx_power_index = tx_index_of(cur_row_q);
      return e;
    end
    searching_q = 1'b0;
    if (opt_row < 0 || opt_row >= ROWS || opt_pwr == '0) begin
      e.status = ST_RANGE;
      return e;
    end
    hp = int'(log2_q) - bit_len(opt_pwr);
    if (hp < 0) hp = 0;
    if (hp > int'(vlim_q)) hp = int'(vlim_q);
    e.status         = ST_DONE;
    e.gain_word      = gain_word_of(opt_row, hp);
    e.tx_power_index = tx_index_of(measured);
    e.best_row       = ROW_W'(opt_row);
    e.best_power     = opt_pwr;
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    req_t got_req;
    rsp_t want;
    if (!rst_ni) begin
      thr_q       = 24'd10000;
      log2_q      = 5'd13;
      srow_q      = 3'd3;
      vlim_q      = 4'd10;
      mixer_q     = 4'd3;
      searching_q = 1'b0;
      walk_q      = WALK_INIT;
      cur_row_q   = 0;
      prev_row_q  = 0;
      prev_pwr_q  = '0;
      core_q      = 1'b0;
      fails       = 0;
      pending_results_q.delete();
      outstanding_o  <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POWER_THRESHOLD:    thr_q   = cfg_data_i[PWR_W-1:0];
          REG_DESIRED_LOG2_POWER: log2_q  = cfg_data_i[4:0];
          REG_START_ROW:          srow_q  = cfg_data_i[ROW_W-1:0];
          REG_VGA_GAIN_LIMIT:     vlim_q  = cfg_data_i[3:0];
          REG_MIXER_TIA_GAIN:     mixer_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results_q.size() == 0) begin
          $error("result with no request waiting: status %0d", rsp.status);
          fails++;
        end else begin
          want = pending_results_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.gain_word !== want.gain_word) begin
            $error("gain_word: expected %04h, got %04h", want.gain_word, rsp.gain_word);
            fails++;
          end
          if (rsp.tx_power_index !== want.tx_power_index) begin
            $error("tx_power_index: expected %0d, got %0d", want.tx_power_index,
                   rsp.tx_power_index);
            fails++;
          end
          if (rsp.tx_core !== want.tx_core) begin
            $error("tx_core: expected %0d, got %0d", want.tx_core, rsp.tx_core);
            fails++;
          end
          if (rsp.best_row !== want.best_row) begin
            $error("best_row: expected %0d, got %0d", want.best_row, rsp.best_row);
            fails++;
          end
          if (rsp.best_power !== want.best_power) begin
            $error("best_power: expected %0d, got %0d", want.best_power,
                   rsp.best_power);
            fails++;
          end
        end
      end
      if (req.valid && req.ready) begin
        got_req.operation         = req.operation;
        got_req.rx_core           = req.rx_core;
        got_req.core0_i_power_sum = req.core0_i_power_sum;
        got_req.core0_q_power_sum = req.core0_q_power_sum;
        got_req.core1_i_power_sum = req.core1_i_power_sum;
        got_req.core1_q_power_sum = req.core1_q_power_sum;
        pending_results_q.push_back(predict_search_result(got_req));
      end
      outstanding_o  <= pending_results_q.size();
      mismatch_cnt_o <= fails;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_rx_gain_row_search.sv
// tb_rx_gain_row_search: drives requests and register writes into rx_gain_row_search,
// stalls the result side and gives the verdict from the failure count of rgrs_search_checker
// depends on rgrs_pkg, rgrs_if, the block and the checker
`default_nettype none

module tb_rx_gain_row_search;
  import rgrs_pkg::*;

  localparam int          PERIOD       = 10;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned MAX_PWR      = 8388608;
  localparam int unsigned HALF_PWR     = 4194304;
  localparam longint      SUM_MAX      = (longint'(1) << SUM_W) - 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          outstanding;
  int unsigned          mismatches;
  int unsigned          cycle_cnt = 0;
  int unsigned          burst_left = 5;
  cfg_t                 cfg_now;

  rgrs_req_if req_ch ();
  rgrs_rsp_if rsp_ch ();

  rx_gain_row_search i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  rgrs_search_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .outstanding_o  (outstanding),
    .mismatch_cnt_o (mismatches)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("rx_gain_row_search verification failed");
      $finish;
    end
  end

  // result side: modes of always ready, coin flips and long stalls
  int unsigned recv_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      recv_mode  = $urandom_range(2, 0);
      mode_left  = $urandom_range(200, 20);
      stall_left = 0;
    end
    mode_left--;
    case (recv_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(1, 0));
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(15, 0) == 0) begin
          stall_left = $urandom_range(25, 1);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic logic [SUM_W-1:0] sum_near(input int unsigned p);
    longint s;
    s = (longint'(p) << SAMPLE_COUNT_LOG2_DEF) - (longint'(1) << (SAMPLE_COUNT_LOG2_DEF - 1))
        + longint'($urandom_range((1 << SAMPLE_COUNT_LOG2_DEF) - 1, 0));
    if (s < 0) s = 0;
    if (s > SUM_MAX) s = SUM_MAX;
    return SUM_W'(s);
  endfunction

  function automatic req_t start_item(input bit core);
    req_t r;
    r.operation         = OP_START;
    r.rx_core           = core;
    r.core0_i_power_sum = $urandom;
    r.core0_q_power_sum = $urandom;
    r.core1_i_power_sum = $urandom;
    r.core1_q_power_sum = $urandom;
    return r;
  endfunction

  // the core under search gets the given sums, the other core noise
  function automatic req_t meas_item(input bit core, input logic [SUM_W-1:0] si,
                                     input logic [SUM_W-1:0] sq);
    req_t r;
    r.operation         = OP_MEASURE;
    r.rx_core           = 1'($urandom_range(1, 0));
    r.core0_i_power_sum = core ? $urandom : si;
    r.core0_q_power_sum = core ? $urandom : sq;
    r.core1_i_power_sum = core ? si : $urandom;
    r.core1_q_power_sum = core ? sq : $urandom;
    return r;
  endfunction

  // power above or at most the threshold, half the time close to it, now and then zero
  function automatic int unsigned pick_power(input bit above);
    int unsigned thr, span, lo, hi;
    thr = cfg_now.power_threshold;
    if ($urandom_range(39, 0) == 0) return 0;
    span = ($urandom_range(1, 0) == 0) ? 64 : MAX_PWR;
    if (above) begin
      if (thr >= MAX_PWR) return MAX_PWR;
      lo = thr + 1;
      hi = (MAX_PWR - thr > span) ? thr + span : MAX_PWR;
    end else begin
      if (thr == 0) return 0;
      hi = thr;
      lo = (thr > span) ? thr - span : 1;
    end
    return $urandom_range(hi, lo);
  endfunction

  task automatic send_req(input req_t r);
    req_ch.valid             <= 1'b1;
    req_ch.operation         <= r.operation;
    req_ch.rx_core           <= r.rx_core;
    req_ch.core0_i_power_sum <= r.core0_i_power_sum;
    req_ch.core0_q_power_sum <= r.core0_q_power_sum;
    req_ch.core1_i_power_sum <= r.core1_i_power_sum;
    req_ch.core1_q_power_sum <= r.core1_q_power_sum;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(8, 1);
    end
  endtask

  task automatic send_measure(input bit core, input bit above);
    int unsigned p, lo, hi, a;
    p  = pick_power(above);
    lo = (p > HALF_PWR) ? p - HALF_PWR : 0;
    hi = (p < HALF_PWR) ? p : HALF_PWR;
    a  = $urandom_range(hi, lo);
    send_req(meas_item(core, sum_near(a), sum_near(p - a)));
  endtask

  // hold requests back until every result is in, then let the pipeline settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_POWER_THRESHOLD, CFG_W'(c.power_threshold));
    write_reg(REG_DESIRED_LOG2_POWER, CFG_W'(c.desired_log2_power));
    write_reg(REG_START_ROW, CFG_W'(c.start_row));
    write_reg(REG_VGA_GAIN_LIMIT, CFG_W'(c.vga_gain_limit));
    write_reg(REG_MIXER_TIA_GAIN, CFG_W'(c.mixer_tia_gain));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cfg_now = c;
  endtask

  initial begin
    cfg_t        c;
    int unsigned budget, sent, n, p_above;
    bit          core;
    rst_ni                   <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_idx                  <= '0;
    cfg_data                 <= '0;
    req_ch.valid             <= 1'b0;
    req_ch.operation         <= OP_START;
    req_ch.rx_core           <= 1'b0;
    req_ch.core0_i_power_sum <= '0;
    req_ch.core0_q_power_sum <= '0;
    req_ch.core1_i_power_sum <= '0;
    req_ch.core1_q_power_sum <= '0;
    cfg_now.power_threshold    = 24'd10000;
    cfg_now.desired_log2_power = 5'd13;
    cfg_now.start_row          = 3'd3;
    cfg_now.vga_gain_limit     = 4'd10;
    cfg_now.mixer_tia_gain     = 4'd3;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walks under the reset settings, threshold 10000 from row 3
    send_req(meas_item(1'b0, '1, '1));                     // measurement while idle
    send_req(start_item(1'b0));
    send_req(meas_item(1'b0, '1, '1));                     // largest power, walk down
    send_req(meas_item(1'b0, 32'(20000 * 1024), '0));
    send_req(meas_item(1'b0, 32'(20000 * 1024), '0));
    send_req(meas_item(1'b0, 32'(10001 * 1024), '0));      // falls off the bottom row
    send_req(start_item(1'b1));
    send_req(meas_item(1'b1, 32'd511, 32'd511));           // both round to zero
    send_req(start_item(1'b1));
    send_req(meas_item(1'b1, 32'd512, '0));                // half rounds up to one
    send_req(meas_item(1'b1, 32'(3000 * 1024), '0));
    send_req(meas_item(1'b1, 32'(9999 * 1024), 32'd1023)); // falls off the top row
    send_req(start_item(1'b0));
    send_req(meas_item(1'b0, 32'(2500 * 1024), 32'(2500 * 1024)));
    send_req(meas_item(1'b0, 32'(10001 * 1024), '0));      // up walk ends one row back
    send_req(start_item(1'b0));
    send_req(meas_item(1'b0, 32'(10000 * 1024), '0));      // exactly at threshold
    send_req(meas_item(1'b0, '1, '0));
    send_req(start_item(1'b1));
    send_req(meas_item(1'b1, 32'(40000 * 1024), '0));
    send_req(meas_item(1'b1, 32'(12 * 1024), '0));         // down walk ends here
    send_req(meas_item(1'b1, 32'(12 * 1024), '0));         // after the search ended
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      c = cfg_now;
      case (phase)
        0: ;
        1: begin
          c.power_threshold    = '0;
          c.desired_log2_power = 5'd31;
          c.start_row          = 3'd0;
          c.vga_gain_limit     = 4'd15;
          c.mixer_tia_gain     = 4'd15;
        end
        2: begin
          c.power_threshold    = 24'(MAX_PWR);
          c.desired_log2_power = 5'd0;
          c.start_row          = 3'd5;
          c.vga_gain_limit     = 4'd0;
          c.mixer_tia_gain     = 4'd0;
        end
        3, 4: begin
          c.power_threshold = 24'($urandom_range(MAX_PWR, 0));
          c.start_row       = (phase == 3) ? 3'd6 : 3'd7;
        end
        default: begin
          c.power_threshold    = ($urandom_range(1, 0) == 0) ? 24'($urandom_range(MAX_PWR, 0))
                                                             : 24'($urandom_range(50000, 0));
          c.desired_log2_power = 5'($urandom_range(31, 0));
          c.start_row          = 3'($urandom_range(5, 0));
          c.vga_gain_limit     = 4'($urandom_range(15, 0));
          c.mixer_tia_gain     = 4'($urandom_range(15, 0));
        end
      endcase
      if (phase != 0) load_config(c);
      budget = (phase == 3 || phase == 4) ? 70 : 210;
      sent   = 0;
      while (sent < budget) begin
        if ($urandom_range(9, 0) == 0) begin
          // stray request with arbitrary content
          send_req(req_t'({1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                           $urandom, $urandom, $urandom, $urandom}));
          sent++;
        end else begin
          core = 1'($urandom_range(1, 0));
          send_req(start_item(core));
          p_above = $urandom_range(100, 0);
          n       = $urandom_range(8, 1);
          repeat (n) send_measure(core, $urandom_range(99, 0) < p_above);
          sent += n + 1;
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("rx_gain_row_search verification clean");
    end else begin
      $display("rx_gain_row_search verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: rx_gain_row_search.f
hdl/rgrs_pkg.sv
hdl/rgrs_if.sv
hdl/rgrs_cfg_regs.sv
hdl/rgrs_power.sv
hdl/rgrs_walk.sv
hdl/rx_gain_row_search.sv
tb/rgrs_search_checker.sv
tb/tb_rx_gain_row_search.sv
